/* hdl/rtyc_pkg.sv */
// package for the rgb to ycbcr 4:2:0 converter: payload types, coefficients and helpers
package rtyc_pkg;

  localparam int unsigned LINE_WIDTH_DEFAULT = 4096;
  localparam int unsigned FRAME_WIDTH_BITS   = 13;
  localparam logic [FRAME_WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 13'd640;

  // coefficients as signed fractions of 2^16
  localparam logic signed [16:0] COEF_Y_R  = 17'sd16828;
  localparam logic signed [16:0] COEF_Y_G  = 17'sd270;
  localparam logic signed [16:0] COEF_Y_B  = 17'sd6416;
  localparam logic signed [16:0] COEF_CB_R = -17'sd9713;
  localparam logic signed [16:0] COEF_CB_G = -17'sd19070;
  localparam logic signed [16:0] COEF_CB_B = 17'sd28784;
  localparam logic signed [16:0] COEF_CR_R = 17'sd28784;
  localparam logic signed [16:0] COEF_CR_G = -17'sd24103;
  localparam logic signed [16:0] COEF_CR_B = -17'sd4681;

  localparam logic signed [11:0] LUMA_OFFSET   = 12'sd16;
  localparam logic signed [11:0] CHROMA_OFFSET = 12'sd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       chroma_valid;
  } pix_out_t;

  // floor(x * c / 2^16); the upper bits of the signed product are the floored quotient
  function automatic logic signed [9:0] mul_high(input logic [7:0] x,
                                                 input logic signed [16:0] c);
    logic signed [25:0] prod;
    prod = $signed({1'b0, x}) * c;
    return prod[25:16];
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

/* hdl/rtyc_pos.sv */
// raster position tracker: column counter, odd row flag and chroma sample select
module rtyc_pos #(
  parameter int unsigned MAX_LINE_WIDTH = rtyc_pkg::LINE_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 frame_start,
  input  logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] frame_width,
  output logic                                 chroma_sel
);

  localparam int unsigned CW   = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned CMPW = (CW + 1 > rtyc_pkg::FRAME_WIDTH_BITS) ?
                                 CW + 1 : rtyc_pkg::FRAME_WIDTH_BITS;

  logic [CW-1:0]   col;
  logic            odd_row;
  logic [CW-1:0]   col_cur;
  logic            odd_cur;
  logic [CMPW-1:0] width_ext;
  logic [CMPW-1:0] width_eff;
  logic            wrap;
  logic [CW-1:0]   col_next;
  logic            odd_row_next;

  always_comb begin
    width_ext = CMPW'(frame_width);
    if (width_ext < CMPW'(2)) begin
      width_eff = CMPW'(2);
    end else if (width_ext > CMPW'(MAX_LINE_WIDTH)) begin
      width_eff = CMPW'(MAX_LINE_WIDTH);
    end else begin
      width_eff = width_ext;
    end

    // a frame start forces column 0 of an even row
    col_cur = frame_start ? '0 : col;
    odd_cur = frame_start ? 1'b0 : odd_row;

    chroma_sel = !odd_cur && !col_cur[0];

    wrap = (CMPW'(col_cur) + CMPW'(1)) >= width_eff;
    if (wrap) begin
      col_next     = '0;
      odd_row_next = !odd_cur;
    end else begin
      col_next     = col_cur + CW'(1);
      odd_row_next = odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      odd_row <= 1'b0;
    end else if (accept) begin
      col     <= col_next;
      odd_row <= odd_row_next;
    end
  end

  a_start_even: assert property (@(posedge clk) disable iff (rst)
    frame_start |-> chroma_sel)
    else $error("frame start pixel not selected for chroma");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    accept && wrap |=> col == '0)
    else $error("column did not return to zero after line wrap");

  a_odd_no_chroma: assert property (@(posedge clk) disable iff (rst)
    accept && wrap && !odd_cur |=> !chroma_sel || frame_start)
    else $error("chroma selected on an odd row");

endmodule

/* hdl/rtyc_csc.sv */
// color conversion datapath: input register, bt.601 matrix with clamps, result register
module rtyc_csc (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtyc_pkg::pix_in_t  in_data,
  input  logic               in_chroma,
  output logic               out_valid,
  input  logic               out_stall,
  output rtyc_pkg::pix_out_t out_data
);

  logic              s1_valid;
  rtyc_pkg::pix_in_t s1_pix;
  logic              s1_chroma;
  logic              out_hold;
  logic              s1_hold;
  logic signed [11:0] y_sum;
  logic signed [11:0] cb_sum;
  logic signed [11:0] cr_sum;
  rtyc_pkg::pix_out_t res_next;

  assign out_hold = out_valid && out_stall;
  assign s1_hold  = s1_valid && out_hold;
  assign in_stall = s1_hold;

  always_comb begin
    y_sum  = 12'(rtyc_pkg::mul_high(s1_pix.red,   rtyc_pkg::COEF_Y_R))
           + 12'(rtyc_pkg::mul_high(s1_pix.green, rtyc_pkg::COEF_Y_G))
           + $signed({5'd0, s1_pix.green[7:1]})
           + 12'(rtyc_pkg::mul_high(s1_pix.blue,  rtyc_pkg::COEF_Y_B))
           + rtyc_pkg::LUMA_OFFSET;
    cb_sum = 12'(rtyc_pkg::mul_high(s1_pix.red,   rtyc_pkg::COEF_CB_R))
           + 12'(rtyc_pkg::mul_high(s1_pix.green, rtyc_pkg::COEF_CB_G))
           + 12'(rtyc_pkg::mul_high(s1_pix.blue,  rtyc_pkg::COEF_CB_B))
           + rtyc_pkg::CHROMA_OFFSET;
    cr_sum = 12'(rtyc_pkg::mul_high(s1_pix.red,   rtyc_pkg::COEF_CR_R))
           + 12'(rtyc_pkg::mul_high(s1_pix.green, rtyc_pkg::COEF_CR_G))
           + 12'(rtyc_pkg::mul_high(s1_pix.blue,  rtyc_pkg::COEF_CR_B))
           + rtyc_pkg::CHROMA_OFFSET;

    res_next.luma         = rtyc_pkg::clamp_u8(y_sum);
    // chroma reads as zero on pixels that carry none
    res_next.chroma_blue  = s1_chroma ? rtyc_pkg::clamp_u8(cb_sum) : 8'd0;
    res_next.chroma_red   = s1_chroma ? rtyc_pkg::clamp_u8(cr_sum) : 8'd0;
    res_next.chroma_valid = s1_chroma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s1_hold) begin
        s1_valid <= in_valid;
      end
      if (!out_hold) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_hold && in_valid) begin
      s1_pix    <= in_data;
      s1_chroma <= in_chroma;
    end
    if (!out_hold && s1_valid) begin
      out_data <= res_next;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free register stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_hold |=> out_valid)
    else $error("transaction lost between stages");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.chroma_valid |->
      out_data.chroma_blue == 8'd0 && out_data.chroma_red == 8'd0)
    else $error("chroma not zero on a pixel without chroma");

endmodule

/* hdl/rgb_to_ycbcr_420.sv */
// top level of the rgb to ycbcr 4:2:0 converter
//
//  channel   direction  handshake              payload
//  pixel     in         pixel_valid/stall      rtyc_pkg::pix_in_t (red, green, blue, frame_start)
//  result    out        result_valid/stall     rtyc_pkg::pix_out_t (luma, cb, cr, chroma_valid)
//  cfg       in         cfg_valid/cfg_ready    frame_width, 13 bits
//
// one pixel per cycle sustained while the result is not stalled; each pixel passes from acceptance
// through the input register, then the result register after the color matrix
// rst clears the position to column 0 of an even row, both stages to empty, width to 640
// a stalled result holds; the input register still takes one more pixel behind it
// cfg_ready is always high
module rgb_to_ycbcr_420 #(
  parameter int unsigned MAX_LINE_WIDTH = rtyc_pkg::LINE_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  rtyc_pkg::pix_in_t                    pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output rtyc_pkg::pix_out_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] cfg_data
);

  logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] frame_width;
  logic                                  pixel_accept;
  logic                                  chroma_sel;

  assign cfg_ready    = 1'b1;
  assign pixel_accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= rtyc_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_width <= cfg_data;
    end
  end

  rtyc_pos #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (pixel_accept),
    .frame_start (pixel.frame_start),
    .frame_width (frame_width),
    .chroma_sel  (chroma_sel)
  );

  rtyc_csc u_csc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .in_data   (pixel),
    .in_chroma (chroma_sel),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result)
  );

endmodule

/* sim/tb.sv */
// testbench for rgb_to_ycbcr_420: directed table then random pixel streams, checked against a predictor
module tb;

  localparam int MAX_W = 4096;
  localparam int HOLD_CYCLES = 80;

  // luma and chroma weights, fractions of 2^16
  localparam int YR_WT = 16828;
  localparam int YG_WT = 270;
  localparam int YB_WT = 6416;
  localparam int CBR_WT = -9713;
  localparam int CBG_WT = -19070;
  localparam int CBB_WT = 28784;
  localparam int CRR_WT = 28784;
  localparam int CRG_WT = -24103;
  localparam int CRB_WT = -4681;
  localparam int NO_WRITE = -1;

  typedef struct {
    int                 new_width;
    rtyc_pkg::pix_in_t  px;
    bit                 typed;
    rtyc_pkg::pix_out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  rtyc_pkg::pix_in_t pixel = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rtyc_pkg::pix_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] cfg_data = '0;

  // predictor state
  logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] line_width = rtyc_pkg::FRAME_WIDTH_RESET;
  int col_pos = 0;
  bit on_odd_row = 1'b0;

  rtyc_pkg::pix_out_t pending_ycbcr[$];
  rtyc_pkg::pix_out_t oldest;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  plan_row_t plan [24] = '{
    '{NO_WRITE, {8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, {8'd16, 8'd128, 8'd128, 1'b1}},
    '{NO_WRITE, {8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, {8'd16, 8'd0, 8'd0, 1'b0}},
    '{NO_WRITE, {8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, {8'd233, 8'd126, 8'd126, 1'b1}},
    '{NO_WRITE, {8'hff, 8'h00, 8'h00, 1'b0}, 1'b1, {8'd81, 8'd0, 8'd0, 1'b0}},
    '{NO_WRITE, {8'hff, 8'h00, 8'h00, 1'b0}, 1'b1, {8'd81, 8'd90, 8'd239, 1'b1}},
    '{NO_WRITE, {8'h00, 8'hff, 8'h00, 1'b0}, 1'b1, {8'd144, 8'd0, 8'd0, 1'b0}},
    '{NO_WRITE, {8'h00, 8'hff, 8'h00, 1'b0}, 1'b1, {8'd144, 8'd53, 8'd34, 1'b1}},
    '{NO_WRITE, {8'h00, 8'h00, 8'hff, 1'b0}, 1'b1, {8'd40, 8'd0, 8'd0, 1'b0}},
    '{NO_WRITE, {8'h00, 8'h00, 8'hff, 1'b0}, 1'b1, {8'd40, 8'd239, 8'd109, 1'b1}},
    '{NO_WRITE, {8'haa, 8'h55, 8'haa, 1'b0}, 1'b0, '0},
    // frame start in mid line
    '{NO_WRITE, {8'h55, 8'haa, 8'h55, 1'b1}, 1'b0, '0},
    // narrowest line: two pixels
    '{2,        {8'hff, 8'h00, 8'hff, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'h80, 8'h7f, 8'h01, 1'b0}, 1'b0, '0},
    // zero width behaves as two
    '{0,        {8'h01, 8'h80, 8'hfe, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'hfe, 8'h01, 8'h7f, 1'b0}, 1'b0, '0},
    // all-ones width clamps to the maximum line width
    '{8191,     {8'h7f, 8'hfe, 8'h80, 1'b1}, 1'b0, '0},
    '{NO_WRITE, {8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'hed, 8'hcb, 8'ha9, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'h3c, 8'hc3, 8'h5a, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'hc3, 8'h3c, 8'ha5, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'h0f, 8'hf0, 8'h81, 1'b0}, 1'b0, '0},
    // shrink while column 6 is next: line wraps after this pixel
    '{4,        {8'hf0, 8'h0f, 8'h18, 1'b0}, 1'b0, '0},
    '{NO_WRITE, {8'h99, 8'h66, 8'he7, 1'b0}, 1'b0, '0}
  };

  rgb_to_ycbcr_420 uut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floored multiply-high
  function automatic int mul_floor16(input logic [7:0] x, input int wt);
    int prod;
    prod = int'(x) * wt;
    return prod >>> 16;
  endfunction

  function automatic logic [7:0] sat8(input int v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic rtyc_pkg::pix_out_t convert_pixel(input rtyc_pkg::pix_in_t p);
    rtyc_pkg::pix_out_t o;
    int eff_w;
    int y;
    int cb;
    int cr;
    eff_w = int'(line_width);
    if (eff_w < 2) eff_w = 2;
    if (eff_w > MAX_W) eff_w = MAX_W;
    if (p.frame_start) begin
      col_pos = 0;
      on_odd_row = 1'b0;
    end
    y = mul_floor16(p.red, YR_WT) + mul_floor16(p.green, YG_WT) + int'(p.green >> 1)
        + mul_floor16(p.blue, YB_WT) + 16;
    o = '0;
    o.luma = sat8(y);
    if (!on_odd_row && (col_pos % 2 == 0)) begin
      cb = mul_floor16(p.red, CBR_WT) + mul_floor16(p.green, CBG_WT)
           + mul_floor16(p.blue, CBB_WT) + 128;
      cr = mul_floor16(p.red, CRR_WT) + mul_floor16(p.green, CRG_WT)
           + mul_floor16(p.blue, CRB_WT) + 128;
      o.chroma_blue = sat8(cb);
      o.chroma_red = sat8(cr);
      o.chroma_valid = 1'b1;
    end
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      on_odd_row = ~on_odd_row;
    end else begin
      col_pos = col_pos + 1;
    end
    return o;
  endfunction

  task automatic send_pixel(input rtyc_pkg::pix_in_t p, input bit typed,
                            input rtyc_pkg::pix_out_t typed_want);
    rtyc_pkg::pix_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    pred = convert_pixel(p);
    pending_ycbcr.push_back(typed ? typed_want : pred);
  endtask

  // stop sending until every pending result is out
  task automatic drain;
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_ycbcr.size() != 0);
  endtask

  task automatic write_width(input logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] w);
    cfg_data <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_width = w;
  endtask

  function automatic logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] pick_width();
    logic [rtyc_pkg::FRAME_WIDTH_BITS-1:0] w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(6))
          0: w = 13'd0;
          1: w = 13'd1;
          2: w = 13'd3;
          3: w = 13'd4096;
          4: w = 13'd4097;
          5: w = 13'd8191;
          default: w = 13'd2;
        endcase
      end
      1, 2: w = 13'($urandom_range(40));
      default: w = 13'(2 * $urandom_range(6, 1));
    endcase
    return w;
  endfunction

  function automatic logic [7:0] pick_level();
    logic [7:0] v;
    case ($urandom_range(7))
      0: v = 8'h00;
      1: v = 8'hff;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic rtyc_pkg::pix_in_t random_pixel();
    rtyc_pkg::pix_in_t p;
    p.red = pick_level();
    p.green = pick_level();
    p.blue = pick_level();
    p.frame_start = ($urandom_range(39) == 0);
    return p;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_ycbcr.size() == 0) begin
        $error("result transaction with nothing pending: %p", result);
        mismatch_count++;
      end else begin
        oldest = pending_ycbcr.pop_front();
        if (result.luma !== oldest.luma) begin
          $error("luma: expected %0d, got %0d", oldest.luma, result.luma);
          mismatch_count++;
        end
        if (result.chroma_blue !== oldest.chroma_blue) begin
          $error("chroma_blue: expected %0d, got %0d", oldest.chroma_blue, result.chroma_blue);
          mismatch_count++;
        end
        if (result.chroma_red !== oldest.chroma_red) begin
          $error("chroma_red: expected %0d, got %0d", oldest.chroma_red, result.chroma_red);
          mismatch_count++;
        end
        if (result.chroma_valid !== oldest.chroma_valid) begin
          $error("chroma_valid: expected %0d, got %0d", oldest.chroma_valid,
                 result.chroma_valid);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 53;
    foreach (plan[i]) begin
      if (plan[i].new_width != NO_WRITE) begin
        drain();
        write_width(rtyc_pkg::FRAME_WIDTH_BITS'(plan[i].new_width));
      end
      send_pixel(plan[i].px, plan[i].typed, plan[i].want);
    end

    // three idling modes, three width settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 53 : 0;
      recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 30 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        drain();
        write_width(pick_width());
        // fill the pipe against a long receiver hold-off
        if (mode == 2 && ph == 1) hold_reqs++;
        for (int n = 0; n < 105; n++) begin
          send_pixel(random_pixel(), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
